/* src/tcle_pkg.sv */
package tcle_pkg;

  localparam int FONT_WIDTH  = 8;
  localparam int FONT_HEIGHT = 16;
  localparam int TAB_COLUMNS = 4;
  localparam int TAB_SPAN    = FONT_WIDTH * TAB_COLUMNS;

  localparam logic [11:0] FW_X     = 12'(FONT_WIDTH);
  localparam logic [11:0] FH_X     = 12'(FONT_HEIGHT);
  localparam logic [12:0] FW_W     = 13'(FONT_WIDTH);
  localparam logic [12:0] FH_W     = 13'(FONT_HEIGHT);
  localparam logic [12:0] FH2_W    = 13'(2 * FONT_HEIGHT);
  localparam logic [11:0] FH2_X    = 12'(2 * FONT_HEIGHT);
  localparam logic [11:0] SPAN_X   = 12'(TAB_SPAN);
  localparam logic [12:0] SPAN_W   = 13'(TAB_SPAN);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // config register indexes
  localparam logic [2:0] CFG_ENABLE = 3'd0;
  localparam logic [2:0] CFG_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_FORE   = 3'd3;
  localparam logic [2:0] CFG_BACK   = 3'd4;
  localparam logic [2:0] CFG_RSHIFT = 3'd5;
  localparam logic [2:0] CFG_GSHIFT = 3'd6;
  localparam logic [2:0] CFG_BSHIFT = 3'd7;

  // character classes
  localparam logic [1:0] CK_NEWLINE = 2'd0;
  localparam logic [1:0] CK_TAB     = 2'd1;
  localparam logic [1:0] CK_BACK    = 2'd2;
  localparam logic [1:0] CK_DRAW    = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_BACK    = 8'd8;

  // command kinds
  localparam logic [1:0] OP_FILL   = 2'd0;
  localparam logic [1:0] OP_GLYPH  = 2'd1;
  localparam logic [1:0] OP_SCROLL = 2'd2;

  // command slots within one character, in issue order
  localparam int SL_ERASE  = 0;
  localparam int SL_PRE    = 1;
  localparam int SL_CHAR   = 2;
  localparam int SL_POST   = 3;
  localparam int SL_CURSOR = 4;
  localparam int NSLOT     = 5;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_of_string;
    logic       last_of_string;
  } tcle_in_t;

  typedef struct packed {
    logic [1:0]  op_kind;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [11:0] span_width;
    logic [7:0]  glyph_code;
    logic [31:0] fill_color;
    logic        last_of_run;
  } tcle_out_t;

  typedef struct packed {
    logic        enable;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
  } tcle_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] glyph;
    logic       first;
    logic       last;
  } tcle_item_t;

  typedef struct packed {
    logic [NSLOT-1:0] mask;
    logic [11:0]      erase_x;
    logic [11:0]      erase_y;
    logic [11:0]      char_x;
    logic [11:0]      char_y;
    logic [11:0]      char_w;
    logic             char_glyph;
    logic [7:0]       glyph;
    logic [11:0]      cur_x;
    logic [11:0]      cur_y;
  } tcle_plan_t;

  function automatic logic [31:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input tcle_cfg_t cfg);
    pack_pixel = (32'(r) << cfg.red_shift) | (32'(g) << cfg.green_shift) |
                 (32'(b) << cfg.blue_shift);
  endfunction

  function automatic logic [7:0] mix_chan(input logic [7:0] f, input logic [7:0] b);
    logic [15:0] sum;
    sum = 16'(f) * 16'd179 + 16'(b) * 16'd77;
    mix_chan = sum[15:8];
  endfunction

endpackage

/* src/tcle_front.sv */
module tcle_front
  import tcle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tcle_in_t   in_data,
  input  logic       enable,
  output logic       q_push,
  output tcle_item_t q_item,
  input  logic       q_full
);

  logic       fr_valid_r;
  tcle_item_t fr_item_r;
  tcle_item_t item_nxt;
  logic       load;

  assign in_stall = fr_valid_r && q_full;
  assign load     = in_valid && !in_stall;
  assign q_push   = fr_valid_r && !q_full;
  assign q_item   = fr_item_r;

  always_comb begin
    item_nxt.glyph = in_data.char_code;
    item_nxt.first = in_data.first_of_string;
    item_nxt.last  = in_data.last_of_string;
    unique case (in_data.char_code)
      CH_NEWLINE: item_nxt.kind = CK_NEWLINE;
      CH_TAB:     item_nxt.kind = CK_TAB;
      CH_BACK:    item_nxt.kind = CK_BACK;
      default:    item_nxt.kind = CK_DRAW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      // disabled console drops the transaction
      if (load && enable) begin
        fr_valid_r <= 1'b1;
      end else if (q_push) begin
        fr_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && enable) begin
      fr_item_r <= item_nxt;
    end
  end

endmodule

/* src/tcle_queue.sv */
module tcle_queue
  import tcle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tcle_item_t din,
  output logic       full,
  input  logic       pop,
  output logic       nonempty,
  output tcle_item_t dout
);

  tcle_item_t      ent_r [QDEPTH];
  logic [QAW-1:0]  wp_r;
  logic [QAW-1:0]  rp_r;
  logic [QAW:0]    cnt_r;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign dout     = ent_r[rp_r];

  function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] p);
    wrap_inc = (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wrap_inc(wp_r);
      end
      if (pop) begin
        rp_r <= wrap_inc(rp_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

endmodule

/* src/tcle_plan.sv */
module tcle_plan
  import tcle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tcle_cfg_t  cfg,
  input  logic       q_valid,
  input  tcle_item_t q_item,
  output logic       q_pop,
  output logic       plan_valid,
  output tcle_plan_t plan,
  input  logic       plan_take
);

  localparam logic [1:0] PS_LOAD = 2'd0;
  localparam logic [1:0] PS_CHAR = 2'd1;
  localparam logic [1:0] PS_POST = 2'd2;

  logic [1:0]  state_r;
  logic [11:0] cx_r;
  logic [11:0] cy_r;
  tcle_item_t  item_r;
  logic [11:0] ex_r;
  logic [11:0] ey_r;
  logic        pre_r;
  logic [11:0] char_x_r;
  logic [11:0] char_y_r;
  logic [11:0] char_w_r;
  logic        char_en_r;
  logic        plan_valid_r;
  tcle_plan_t  plan_r;

  logic             pre_scroll;
  logic [11:0]      cy_pre;
  logic [11:0]      cy_nl;
  logic [12:0]      tab_col;
  logic [12:0]      tab_nx;
  logic             tab_fit;
  logic [11:0]      cxa;
  logic             draw_wrap;
  logic [11:0]      cx_nxt;
  logic [11:0]      cy_nxt;
  logic [11:0]      cw_nxt;
  logic             cen_nxt;
  logic             post_scroll;
  logic [11:0]      cy_post;
  logic             slot_free;
  logic [NSLOT-1:0] mask;

  assign plan_valid = plan_valid_r;
  assign plan       = plan_r;
  assign q_pop      = (state_r == PS_LOAD) && q_valid;
  assign slot_free  = !plan_valid_r || plan_take;

  // scroll before a drawn glyph: cursor_y + 2*font_height reaches the screen height
  always_comb begin
    pre_scroll = (q_item.kind == CK_DRAW) && (({1'b0, cy_r} + FH2_W) >= {1'b0, cfg.screen_height});
    cy_pre     = (pre_scroll && cy_r >= FH_X) ? cy_r - FH_X : cy_r;
  end

  always_comb begin
    cy_nl     = cy_r + FH_X;
    tab_col   = 13'(cx_r / SPAN_X) + 13'd1;
    tab_nx    = tab_col * SPAN_W;
    tab_fit   = (tab_nx < {1'b0, cfg.screen_width}) && (tab_nx > {1'b0, cx_r});
    cxa       = cx_r + FW_X;
    draw_wrap = ({1'b0, cxa} + FW_W) >= {1'b0, cfg.screen_width};
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cw_nxt    = '0;
    cen_nxt   = 1'b0;
    unique case (item_r.kind)
      CK_NEWLINE: begin
        cx_nxt = '0;
        cy_nxt = cy_nl;
      end
      CK_TAB: begin
        if (tab_fit) begin
          cx_nxt  = tab_nx[11:0];
          cw_nxt  = tab_nx[11:0] - cx_r;
          cen_nxt = 1'b1;
        end else begin
          cx_nxt  = '0;
          cy_nxt  = cy_nl;
          cw_nxt  = cfg.screen_width - cx_r;
          cen_nxt = cx_r < cfg.screen_width;
        end
      end
      CK_BACK: begin
        cx_nxt = (cx_r >= FW_X) ? cx_r - FW_X : '0;
      end
      default: begin
        cen_nxt = 1'b1;
        if (draw_wrap) begin
          cx_nxt = '0;
          cy_nxt = cy_nl;
        end else begin
          cx_nxt = cxa;
        end
      end
    endcase
  end

  always_comb begin
    post_scroll = ({1'b0, cy_r} + FH_W) >= {1'b0, cfg.screen_height};
    cy_post     = (post_scroll && cy_r >= FH_X) ? cy_r - FH_X : cy_r;
    mask               = '0;
    mask[SL_ERASE]     = item_r.first;
    mask[SL_PRE]       = pre_r;
    mask[SL_CHAR]      = char_en_r;
    mask[SL_POST]      = post_scroll;
    mask[SL_CURSOR]    = item_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= PS_LOAD;
      cx_r         <= '0;
      cy_r         <= '0;
      plan_valid_r <= 1'b0;
    end else begin
      if (state_r == PS_POST && slot_free) begin
        plan_valid_r <= |mask;
      end else if (plan_take) begin
        plan_valid_r <= 1'b0;
      end
      unique case (state_r)
        PS_LOAD: begin
          if (q_valid) begin
            cy_r    <= cy_pre;
            state_r <= PS_CHAR;
          end
        end
        PS_CHAR: begin
          cx_r    <= cx_nxt;
          cy_r    <= cy_nxt;
          state_r <= PS_POST;
        end
        PS_POST: begin
          if (slot_free) begin
            cy_r    <= cy_post;
            state_r <= PS_LOAD;
          end
        end
        default: state_r <= PS_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == PS_LOAD && q_valid) begin
      item_r <= q_item;
      ex_r   <= cx_r;
      ey_r   <= cy_r;
      pre_r  <= pre_scroll;
    end
    if (state_r == PS_CHAR) begin
      char_x_r  <= cx_r;
      char_y_r  <= cy_r;
      char_w_r  <= cw_nxt;
      char_en_r <= cen_nxt;
    end
    if (state_r == PS_POST && slot_free) begin
      plan_r.mask       <= mask;
      plan_r.erase_x    <= ex_r;
      plan_r.erase_y    <= ey_r;
      plan_r.char_x     <= char_x_r;
      plan_r.char_y     <= char_y_r;
      plan_r.char_w     <= char_w_r;
      plan_r.char_glyph <= (item_r.kind == CK_DRAW);
      plan_r.glyph      <= item_r.glyph;
      plan_r.cur_x      <= cx_r;
      plan_r.cur_y      <= cy_post;
    end
  end

endmodule

/* src/tcle_emit.sv */
module tcle_emit
  import tcle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tcle_cfg_t  cfg,
  input  logic       plan_valid,
  input  tcle_plan_t plan,
  output logic       plan_take,
  output logic       out_valid,
  input  logic       out_stall,
  output tcle_out_t  out_data
);

  logic [NSLOT-1:0] mask_r;
  tcle_plan_t       pl_r;
  logic             out_valid_r;
  tcle_out_t        out_r;

  logic [NSLOT-1:0] clr;
  logic [NSLOT-1:0] mask_left;
  logic             adv;
  tcle_out_t        cmd;
  logic [31:0]      back_pix;
  logic [31:0]      cur_pix;
  logic [11:0]      scroll_top;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign adv       = !out_valid_r || !out_stall;
  assign plan_take = plan_valid && (mask_r == '0);

  always_comb begin
    back_pix   = pack_pixel(cfg.back_rgb[23:16], cfg.back_rgb[15:8], cfg.back_rgb[7:0], cfg);
    cur_pix    = pack_pixel(mix_chan(cfg.fore_rgb[23:16], cfg.back_rgb[23:16]),
                            mix_chan(cfg.fore_rgb[15:8], cfg.back_rgb[15:8]),
                            mix_chan(cfg.fore_rgb[7:0], cfg.back_rgb[7:0]), cfg);
    scroll_top = (cfg.screen_height >= FH2_X) ? cfg.screen_height - FH2_X : '0;
  end

  always_comb begin
    clr             = '0;
    cmd.op_kind     = OP_FILL;
    cmd.x_pos       = '0;
    cmd.y_pos       = '0;
    cmd.span_width  = '0;
    cmd.glyph_code  = '0;
    cmd.fill_color  = '0;
    cmd.last_of_run = 1'b0;
    if (mask_r[SL_ERASE]) begin
      clr[SL_ERASE]  = 1'b1;
      cmd.x_pos      = pl_r.erase_x;
      cmd.y_pos      = pl_r.erase_y;
      cmd.span_width = FW_X;
      cmd.fill_color = back_pix;
    end else if (mask_r[SL_PRE] || (!mask_r[SL_CHAR] && mask_r[SL_POST])) begin
      if (mask_r[SL_PRE]) begin
        clr[SL_PRE] = 1'b1;
      end else begin
        clr[SL_POST] = 1'b1;
      end
      cmd.op_kind    = OP_SCROLL;
      cmd.y_pos      = scroll_top;
      cmd.span_width = cfg.screen_width;
      cmd.fill_color = back_pix;
    end else if (mask_r[SL_CHAR]) begin
      clr[SL_CHAR] = 1'b1;
      cmd.x_pos    = pl_r.char_x;
      cmd.y_pos    = pl_r.char_y;
      if (pl_r.char_glyph) begin
        cmd.op_kind    = OP_GLYPH;
        cmd.glyph_code = pl_r.glyph;
      end else begin
        cmd.span_width = pl_r.char_w;
        cmd.fill_color = back_pix;
      end
    end else if (mask_r[SL_CURSOR]) begin
      clr[SL_CURSOR] = 1'b1;
      cmd.x_pos      = pl_r.cur_x;
      cmd.y_pos      = pl_r.cur_y;
      cmd.span_width = FW_X;
      cmd.fill_color = cur_pix;
    end
    mask_left       = mask_r & ~clr;
    cmd.last_of_run = (mask_left == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (plan_take) begin
        mask_r <= plan.mask;
      end else if (adv) begin
        mask_r <= mask_left;
      end
      if (adv) begin
        out_valid_r <= (mask_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (plan_take) begin
      pl_r <= plan;
    end
    if (adv && mask_r != '0) begin
      out_r <= cmd;
    end
  end

endmodule

/* src/text_console_layout_engine.sv */
// path: input register, queue, planner (load, char, post), plan register, output register
// throughput: one command per cycle at the output unless out_stall holds it; the planner
// takes a character after the last one's post state; the issue stage takes a new plan once
// the last plan is issued; a 2-entry queue between input stage and planner absorbs stalls
// reset: synchronous active-low, clears cursor to 0,0 and restores register defaults
module text_console_layout_engine
  import tcle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tcle_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tcle_out_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  tcle_cfg_t  cfg_r;
  logic       q_push;
  tcle_item_t q_in;
  logic       q_full;
  logic       q_pop;
  logic       q_nonempty;
  tcle_item_t q_out;
  logic       plan_valid;
  tcle_plan_t plan;
  logic       plan_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.screen_width  <= 12'd640;
      cfg_r.screen_height <= 12'd480;
      cfg_r.fore_rgb      <= 24'hFFFFFF;
      cfg_r.back_rgb      <= 24'h000000;
      cfg_r.red_shift     <= 5'd16;
      cfg_r.green_shift   <= 5'd8;
      cfg_r.blue_shift    <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: cfg_r.enable        <= cfg_wdata[0];
        CFG_WIDTH:  cfg_r.screen_width  <= cfg_wdata[11:0];
        CFG_HEIGHT: cfg_r.screen_height <= cfg_wdata[11:0];
        CFG_FORE:   cfg_r.fore_rgb      <= cfg_wdata;
        CFG_BACK:   cfg_r.back_rgb      <= cfg_wdata;
        CFG_RSHIFT: cfg_r.red_shift     <= cfg_wdata[4:0];
        CFG_GSHIFT: cfg_r.green_shift   <= cfg_wdata[4:0];
        CFG_BSHIFT: cfg_r.blue_shift    <= cfg_wdata[4:0];
        default:    cfg_r.enable        <= cfg_r.enable;
      endcase
    end
  end

  tcle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .enable   (cfg_r.enable),
    .q_push   (q_push),
    .q_item   (q_in),
    .q_full   (q_full)
  );

  tcle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .din      (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .dout     (q_out)
  );

  tcle_plan u_plan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_nonempty),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_take  (plan_take)
  );

  tcle_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_take  (plan_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
